// File: rtl/lpht_pkg.sv
// Shared constants and types for the linear-probing hash table.
package lpht_pkg;

    localparam int TABLE_SIZE = 2048;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 34;
    localparam int VAL_W      = 32;
    localparam int SLOT_W     = 11;
    localparam int STATUS_W   = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_KEY   = 3'd4
    } status_t;

endpackage

// File: rtl/lpht_if.sv
// Valid/ready channel interfaces for the request and response sides of the hash table.
interface lpht_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [lpht_pkg::KEY_W-1:0]   lookup_key;
    logic [lpht_pkg::VAL_W-1:0]   payload;

    modport source (output valid, output operation, output lookup_key, output payload,
                    input ready);
    modport sink   (input valid, input operation, input lookup_key, input payload,
                    output ready);
endinterface

interface lpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::SLOT_W-1:0]   slot;
    logic [lpht_pkg::VAL_W-1:0]    found_value;

    modport source (output valid, output status, output slot, output found_value,
                    input ready);
    modport sink   (input valid, input status, input slot, input found_value,
                    output ready);
endinterface

// File: rtl/lpht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/linear_probe_hash_table_core.sv
// Top level of the linear-probing hash table: probe sequencer, key and value memories.
//
// After reset the block sweeps the key memory, writing one empty slot per cycle, so it
// accepts no request until all TABLE_SIZE slots have been cleared. It then takes one request
// at a time. A request with a zero key is answered without any probe. Otherwise each probe
// reads the key and value memories at the current slot (S_PROBE) and then compares (S_CHECK),
// for at most TABLE_SIZE probes. The request side is ready again once the response has been
// placed in the output register, even while that response still waits to be taken.
module linear_probe_hash_table_core (
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [lpht_pkg::IDX_W-1:0]    clr_reg, clr_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic                          op_reg, op_next;
    logic [lpht_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [lpht_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [lpht_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [lpht_pkg::IDX_W-1:0]    cnt_reg, cnt_next;
    lpht_pkg::status_t             res_status_reg, res_status_next;
    logic [lpht_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [lpht_pkg::VAL_W-1:0]    res_value_reg, res_value_next;
    lpht_pkg::status_t             rsp_status_reg, rsp_status_next;
    logic [lpht_pkg::SLOT_W-1:0]   rsp_slot_reg, rsp_slot_next;
    logic [lpht_pkg::VAL_W-1:0]    rsp_value_reg, rsp_value_next;

    logic [lpht_pkg::IDX_W-1:0]    home;
    logic [lpht_pkg::IDX_W-1:0]    idx_inc;
    logic                          last_probe;
    logic                          slot_empty;
    logic                          slot_match;
    logic                          req_xfer;
    logic                          rsp_free;

    logic                          key_we;
    logic [lpht_pkg::IDX_W-1:0]    key_waddr;
    logic [lpht_pkg::KEY_W-1:0]    key_wdata;
    logic [lpht_pkg::KEY_W-1:0]    key_rdata;
    logic                          val_we;
    logic [lpht_pkg::VAL_W-1:0]    val_rdata;
    logic                          mem_re;

    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_W),
        .DEPTH (lpht_pkg::TABLE_SIZE)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (key_rdata)
    );

    lpht_ram #(
        .WIDTH (lpht_pkg::VAL_W),
        .DEPTH (lpht_pkg::TABLE_SIZE)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (idx_reg),
        .wdata (val_reg),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (val_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.slot        = rsp_slot_reg;
    assign rsp.found_value = rsp_value_reg;

    assign req_xfer   = req.valid && req.ready;
    assign rsp_free   = !rsp_valid_reg || rsp.ready;
    assign home       = lpht_pkg::IDX_W'(req.lookup_key % lpht_pkg::TABLE_SIZE);
    assign idx_inc    = (idx_reg == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1))
                        ? '0 : idx_reg + 1'b1;
    assign last_probe = (cnt_reg == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1));
    assign slot_empty = (key_rdata == '0);
    assign slot_match = (key_rdata == key_reg);

    assign mem_re    = (state_reg == S_PROBE);
    assign val_we    = (state_reg == S_CHECK) && (op_reg == lpht_pkg::OP_INSERT) && slot_empty;
    assign key_we    = (state_reg == S_CLEAR) || val_we;
    assign key_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
    assign key_wdata = (state_reg == S_CLEAR) ? '0 : key_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_value_next  = rsp_value_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next  = req.operation;
                    key_next = req.lookup_key;
                    val_next = req.payload;
                    idx_next = home;
                    cnt_next = '0;
                    if (req.lookup_key == '0)
                    begin
                        res_status_next = lpht_pkg::ST_BAD_KEY;
                        res_slot_next   = '0;
                        res_value_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_slot_next  = '0;
                res_value_next = '0;
                state_next     = S_DONE;
                if (op_reg == lpht_pkg::OP_INSERT)
                begin
                    if (slot_empty)
                    begin
                        res_status_next = lpht_pkg::ST_INSERTED;
                        res_slot_next   = lpht_pkg::SLOT_W'(idx_reg);
                    end
                    else if (last_probe)
                    begin
                        res_status_next = lpht_pkg::ST_FULL;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    if (slot_match)
                    begin
                        res_status_next = lpht_pkg::ST_FOUND;
                        res_slot_next   = lpht_pkg::SLOT_W'(idx_reg);
                        res_value_next  = val_rdata;
                    end
                    else if (slot_empty || last_probe)
                    begin
                        res_status_next = lpht_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_PROBE;
                    end
                end
            end
            S_DONE:
            begin
                // The result waits here until the output register is free or being emptied.
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    rsp_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_value_reg  <= rsp_value_next;
    end

`ifndef SYNTHESIS
    // The probe slot always lies the probe count beyond the home slot, with wrap-around.
    a_probe_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CHECK)
        |-> (idx_reg == lpht_pkg::IDX_W'(key_reg + lpht_pkg::KEY_W'(cnt_reg))))
        else $error("probe slot does not follow the home slot and probe count");

    // An insert never overwrites an occupied slot.
    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (key_we && state_reg != S_CLEAR) |-> (state_reg == S_CHECK && key_rdata == '0))
        else $error("insert wrote over an occupied slot");

    // A lookup that meets its key is reported as found at that slot.
    a_lookup_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && op_reg == lpht_pkg::OP_LOOKUP && slot_match)
        |=> (state_reg == S_DONE && res_status_reg == lpht_pkg::ST_FOUND
             && res_slot_reg == lpht_pkg::SLOT_W'($past(idx_reg))))
        else $error("lookup hit not reported as found");
`endif

endmodule

// File: test/tb_linear_probe_hash_table_core.sv
// Self-checking testbench for the linear-probing hash table core.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;

    localparam int RESET_CYCLES = 11;
    localparam int STALL_PCT    = 18;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_TAIL  = 20;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic                       op;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::VAL_W-1:0] data;
    } hash_req_t;

    typedef struct packed {
        lpht_pkg::status_t           status;
        logic [lpht_pkg::SLOT_W-1:0] slot;
        logic [lpht_pkg::VAL_W-1:0]  found_value;
    } hash_rsp_t;

    logic clk;
    logic rst_n;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the table contents, updated as each request is accepted.
    logic [lpht_pkg::KEY_W-1:0] slot_keys   [lpht_pkg::TABLE_SIZE] = '{default: '0};
    logic [lpht_pkg::VAL_W-1:0] slot_values [lpht_pkg::TABLE_SIZE];

    hash_rsp_t                  pending_results[$];
    logic [lpht_pkg::KEY_W-1:0] stored_keys[$];
    int                         error_count = 0;
    int                         hold_cycles = 0;
    bit                         steady      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic hash_rsp_t probe_table(input hash_req_t r);
        hash_rsp_t       res;
        longint unsigned wide_key;
        int unsigned     idx;
        res.status      = lpht_pkg::ST_NOT_FOUND;
        res.slot        = '0;
        res.found_value = '0;
        if (r.key == '0)
        begin
            res.status = lpht_pkg::ST_BAD_KEY;
            return res;
        end
        wide_key = r.key;
        idx      = int'(wide_key % lpht_pkg::TABLE_SIZE);
        if (r.op == lpht_pkg::OP_INSERT)
        begin
            for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++)
            begin
                if (slot_keys[idx] == '0)
                begin
                    slot_keys[idx]   = r.key;
                    slot_values[idx] = r.data;
                    res.status       = lpht_pkg::ST_INSERTED;
                    res.slot         = lpht_pkg::SLOT_W'(idx);
                    return res;
                end
                idx = (idx + 1 == lpht_pkg::TABLE_SIZE) ? 0 : idx + 1;
            end
            res.status = lpht_pkg::ST_FULL;
            return res;
        end
        for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++)
        begin
            if (slot_keys[idx] == r.key)
            begin
                res.status      = lpht_pkg::ST_FOUND;
                res.slot        = lpht_pkg::SLOT_W'(idx);
                res.found_value = slot_values[idx];
                return res;
            end
            if (slot_keys[idx] == '0)
                break;
            idx = (idx + 1 == lpht_pkg::TABLE_SIZE) ? 0 : idx + 1;
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Result checking and prediction, both sampled at the rising edge.
    always @(posedge clk)
    begin : monitor
        hash_rsp_t exp_rsp;
        hash_req_t acc_req;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_error($sformatf("response with nothing expected: status %0d slot %0d",
                                           rsp_ch.status, rsp_ch.slot));
                else
                begin
                    exp_rsp = pending_results.pop_front();
                    if (rsp_ch.status !== exp_rsp.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               rsp_ch.status, exp_rsp.status));
                    if (rsp_ch.slot !== exp_rsp.slot)
                        report_error($sformatf("slot %0d, expected %0d",
                                               rsp_ch.slot, exp_rsp.slot));
                    if (rsp_ch.found_value !== exp_rsp.found_value)
                        report_error($sformatf("found_value %08h, expected %08h",
                                               rsp_ch.found_value, exp_rsp.found_value));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                acc_req.op   = req_ch.operation;
                acc_req.key  = req_ch.lookup_key;
                acc_req.data = req_ch.payload;
                pending_results.push_back(probe_table(acc_req));
                if (acc_req.op == lpht_pkg::OP_INSERT && acc_req.key != '0)
                    stored_keys.push_back(acc_req.key);
            end
        end
    end

    // The response side stalls at random, or for a long stretch when asked.
    initial
    begin : response_sink
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no transfer for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(input logic op, input logic [lpht_pkg::KEY_W-1:0] key,
                                input logic [lpht_pkg::VAL_W-1:0] data);
        if (!steady)
        begin
            while ($urandom_range(99) < STALL_PCT)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.lookup_key <= key;
        req_ch.payload    <= data;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Half the keys land near the top of the table so that long probe chains form and wrap.
    task automatic send_random_item();
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [lpht_pkg::KEY_W-1:0] old_key;
        int unsigned                pick;
        pick = $urandom_range(99);
        key  = lpht_pkg::KEY_W'({$urandom, $urandom});
        if ($urandom_range(1) == 1)
            key[lpht_pkg::IDX_W-1:0] = lpht_pkg::IDX_W'($urandom_range(
                lpht_pkg::TABLE_SIZE - 8, lpht_pkg::TABLE_SIZE + 7));
        if ($urandom_range(7) == 0)
            key[lpht_pkg::KEY_W-1:lpht_pkg::IDX_W] = '0;
        old_key = (stored_keys.size() != 0) ?
                  stored_keys[$urandom_range(stored_keys.size() - 1)] : key;
        if (pick < 40)
            send_request(lpht_pkg::OP_INSERT, key, $urandom);
        else if (pick < 48)
            send_request(lpht_pkg::OP_INSERT, old_key, $urandom);
        else if (pick < 83)
            send_request(lpht_pkg::OP_LOOKUP, old_key, $urandom);
        else if (pick < 95)
            send_request(lpht_pkg::OP_LOOKUP, key, $urandom);
        else
            send_request(logic'($urandom_range(1)), '0, $urandom);
    endtask

    task automatic test_directed_cases();
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_ONE   = 34'h0_0000_0001;
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_MAX   = 34'h3_FFFF_FFFF;
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_WRAP  = 34'h0_0000_0FFF;
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_HOME0 = 34'h0_0000_0800;
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_ALT_A = 34'h2_AAAA_AAAA;
        localparam logic [lpht_pkg::KEY_W-1:0] KEY_ALT_B = 34'h1_5555_5555;
        send_request(lpht_pkg::OP_INSERT, KEY_ONE,   32'hFFFF_FFFF);
        send_request(lpht_pkg::OP_INSERT, KEY_MAX,   32'h0000_0000);
        // Home slot is the last one and taken, so this one wraps round to slot 0.
        send_request(lpht_pkg::OP_INSERT, KEY_WRAP,  32'hA5A5_A5A5);
        send_request(lpht_pkg::OP_INSERT, KEY_HOME0, 32'h5A5A_5A5A);
        send_request(lpht_pkg::OP_INSERT, KEY_ONE,   32'h1234_5678);
        send_request(lpht_pkg::OP_INSERT, KEY_ALT_A, 32'hAAAA_AAAA);
        send_request(lpht_pkg::OP_INSERT, KEY_ALT_B, 32'h5555_5555);
        // The first of the duplicate keys must be the one that answers.
        send_request(lpht_pkg::OP_LOOKUP, KEY_ONE,   32'hFFFF_FFFF);
        send_request(lpht_pkg::OP_LOOKUP, KEY_MAX,   32'h0000_0000);
        send_request(lpht_pkg::OP_LOOKUP, KEY_WRAP,  32'h0000_0000);
        send_request(lpht_pkg::OP_LOOKUP, KEY_HOME0, 32'hFFFF_FFFF);
        send_request(lpht_pkg::OP_LOOKUP, KEY_ALT_A, 32'h5555_5555);
        send_request(lpht_pkg::OP_LOOKUP, KEY_ALT_B, 32'hAAAA_AAAA);
        // A miss that walks across the wrap before it meets an empty slot.
        send_request(lpht_pkg::OP_LOOKUP, 34'h0_0000_1FFF, 32'h0000_0000);
        send_request(lpht_pkg::OP_LOOKUP, 34'h0_0000_0005, 32'h0000_0000);
        send_request(lpht_pkg::OP_INSERT, '0, 32'hFFFF_FFFF);
        send_request(lpht_pkg::OP_LOOKUP, '0, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        repeat (600) send_random_item();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (250) send_random_item();
        steady = 1'b0;
    endtask

    // The receiver holds off long enough for the output register to fill and the
    // request side to stop accepting transfers.
    task automatic test_output_backpressure();
        hold_cycles = 300;
        repeat (20) send_random_item();
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (40) send_random_item();
        wait_drained();
        repeat (40) send_random_item();
    endtask

    task automatic test_crowded_top();
        wait_drained();
        send_request(lpht_pkg::OP_INSERT, 34'h0_0000_27FF, 32'hDEAD_BEEF);
        send_request(lpht_pkg::OP_LOOKUP, 34'h3_FFFF_F805, 32'h0000_0000);
        send_request(lpht_pkg::OP_LOOKUP, 34'h0_0000_0001, 32'h0000_0000);
        send_request(lpht_pkg::OP_INSERT, '0, 32'h0000_0000);
        send_request(lpht_pkg::OP_LOOKUP, 34'h3_FFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= lpht_pkg::OP_INSERT;
        req_ch.lookup_key <= '0;
        req_ch.payload    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic();
        test_steady_stream();
        test_output_backpressure();
        test_drain_pause();
        test_crowded_top();

        wait_drained();
        repeat (SETTLE_TAIL) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d responses never arrived", pending_results.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
